@@ hdl/tsw_pkg.sv @@
// Shared types and constants for the texture sampler with repeat wrap.
// No dependencies; the other files of the block, except tsw_ram, refer to it by scoped names.
`timescale 1ns / 1ps

package tsw_pkg;

   // Image and store limits
   localparam int MAX_DIM     = 256;
   localparam int PIXEL_DEPTH = 65536;

   localparam int COORD_W  = $clog2(MAX_DIM);    // texel column / row
   localparam int DIM_W    = COORD_W + 1;        // width / height registers
   localparam int FRAC_W   = 16;                 // u, v and blend weights
   localparam int SCALED_W = FRAC_W + DIM_W;     // u * width
   localparam int ADDR_W   = $clog2(PIXEL_DEPTH);
   localparam int LIN_W    = COORD_W + DIM_W + 1; // x + y * width before range check
   localparam int INDEX_W  = 16;
   localparam int PIXEL_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = PIXEL_W / CHAN_W;
   localparam int WEIGHT_W = FRAC_W + 1;
   localparam int HBLEND_W = CHAN_W + FRAC_W;
   localparam int ACC_W    = CHAN_W + 2 * FRAC_W;

   // Request word layout
   localparam int REQ_IDX_LSB = 0;
   localparam int REQ_VAL_LSB = REQ_IDX_LSB + INDEX_W;
   localparam int REQ_U_LSB   = REQ_VAL_LSB + PIXEL_W;
   localparam int REQ_V_LSB   = REQ_U_LSB + FRAC_W;
   localparam int REQ_DATA_W  = REQ_V_LSB + FRAC_W;
   localparam int RSP_DATA_W  = PIXEL_W;

   // Register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = DIM_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE   = CSR_ADDR_W'(2);

   // Result buffer
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = OUT_PTR_W + 1;

   // Fixed-point constants
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1) << FRAC_W;
   localparam logic [SCALED_W:0]   NEAR_HALF    = (SCALED_W + 1)'(1) << (FRAC_W - 1);
   localparam logic [ACC_W:0]      ROUND_HALF   = (ACC_W + 1)'(1) << (2 * FRAC_W - 1);
   localparam logic [CHAN_W:0]     CHAN_MAX     = (CHAN_W + 1)'((1 << CHAN_W) - 1);

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic {
      MODE_NEAREST  = 1'b0,
      MODE_BILINEAR = 1'b1
   } mode_type;

   // Texel read order of a bilinear sample
   typedef enum logic [1:0] {
      STEP_X0Y0 = 2'd0,
      STEP_X0Y1 = 2'd1,
      STEP_X1Y0 = 2'd2,
      STEP_X1Y1 = 2'd3
   } step_type;

   // One decoded word, ready for the memory sequencer
   typedef struct packed {
      op_type                op;
      mode_type              mode;
      logic [COORD_W-1:0]    x0;
      logic [COORD_W-1:0]    x1;
      logic [COORD_W-1:0]    y0;
      logic [COORD_W-1:0]    y1;
      logic [FRAC_W-1:0]     fx;
      logic [FRAC_W-1:0]     fy;
      logic [INDEX_W-1:0]    idx;
      logic [PIXEL_W-1:0]    val;
   } job_type;

   // Travels with each texel read, aligned with the memory read data
   typedef struct packed {
      logic                  last;   // read that completes a sample
      mode_type              mode;
      logic                  zero;   // address beyond the store, reads as zero
      logic [FRAC_W-1:0]     fx;
      logic [FRAC_W-1:0]     fy;
   } tag_type;

endpackage

@@ hdl/tsw_ram.sv @@
// Generic single-port synchronous RAM, registered read, read-before-write.
// No dependencies.
`timescale 1ns / 1ps

module tsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/tsw_coord.sv @@
// Front end: scales u, v by the image size and derives texel coordinates and weights.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

module tsw_coord (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  tsw_pkg::op_type               in_op,
   input  logic [tsw_pkg::INDEX_W-1:0]   in_idx,
   input  logic [tsw_pkg::PIXEL_W-1:0]   in_val,
   input  logic [tsw_pkg::FRAC_W-1:0]    in_u,
   input  logic [tsw_pkg::FRAC_W-1:0]    in_v,
   input  logic [tsw_pkg::DIM_W-1:0]     width,
   input  logic [tsw_pkg::DIM_W-1:0]     height,
   input  tsw_pkg::mode_type             mode,
   output logic                          job_valid,
   input  logic                          job_ready,
   output tsw_pkg::job_type              job
);

   // stage A: scaled coordinates
   logic                               a_valid_ff, a_valid_in;
   tsw_pkg::op_type                    a_op_ff;
   logic [tsw_pkg::INDEX_W-1:0]        a_idx_ff;
   logic [tsw_pkg::PIXEL_W-1:0]        a_val_ff;
   logic [tsw_pkg::SCALED_W-1:0]       a_sx_ff, a_sy_ff, a_sx_in, a_sy_in;
   logic                               a_take, in_take;

   // stage B: decoded job
   logic                               b_valid_ff, b_valid_in;
   tsw_pkg::job_type                   b_job_ff, b_job_in;

   logic [tsw_pkg::SCALED_W:0]         rx, ry;
   logic [tsw_pkg::DIM_W:0]            xr, yr;
   logic [tsw_pkg::DIM_W-1:0]          xf, yf, xp, yp;

   assign a_take   = a_valid_ff && (!b_valid_ff || job_ready);
   assign in_ready = !a_valid_ff || a_take;
   assign in_take  = in_valid && in_ready;

   assign a_sx_in = tsw_pkg::SCALED_W'(in_u) * tsw_pkg::SCALED_W'(width);
   assign a_sy_in = tsw_pkg::SCALED_W'(in_v) * tsw_pkg::SCALED_W'(height);

   assign a_valid_in = in_take || (a_valid_ff && !a_take);
   assign b_valid_in = a_take || (b_valid_ff && !job_ready);

   always_comb begin
      // nearest: round, then wrap the one value that can reach the size
      rx = (tsw_pkg::SCALED_W + 1)'(a_sx_ff) + tsw_pkg::NEAR_HALF;
      ry = (tsw_pkg::SCALED_W + 1)'(a_sy_ff) + tsw_pkg::NEAR_HALF;
      xr = rx[tsw_pkg::SCALED_W:tsw_pkg::FRAC_W];
      yr = ry[tsw_pkg::SCALED_W:tsw_pkg::FRAC_W];
      // bilinear: floor is always below the size
      xf = a_sx_ff[tsw_pkg::SCALED_W-1:tsw_pkg::FRAC_W];
      yf = a_sy_ff[tsw_pkg::SCALED_W-1:tsw_pkg::FRAC_W];
      xp = xf + tsw_pkg::DIM_W'(1);
      yp = yf + tsw_pkg::DIM_W'(1);

      b_job_in      = '0;
      b_job_in.op   = a_op_ff;
      b_job_in.mode = mode;
      b_job_in.idx  = a_idx_ff;
      b_job_in.val  = a_val_ff;
      b_job_in.fx   = a_sx_ff[tsw_pkg::FRAC_W-1:0];
      b_job_in.fy   = a_sy_ff[tsw_pkg::FRAC_W-1:0];
      if (mode == tsw_pkg::MODE_BILINEAR) begin
         b_job_in.x0 = xf[tsw_pkg::COORD_W-1:0];
         b_job_in.y0 = yf[tsw_pkg::COORD_W-1:0];
         b_job_in.x1 = (xp == width)  ? '0 : xp[tsw_pkg::COORD_W-1:0];
         b_job_in.y1 = (yp == height) ? '0 : yp[tsw_pkg::COORD_W-1:0];
      end else begin
         b_job_in.x0 = (xr == (tsw_pkg::DIM_W + 1)'(width))  ? '0 : xr[tsw_pkg::COORD_W-1:0];
         b_job_in.y0 = (yr == (tsw_pkg::DIM_W + 1)'(height)) ? '0 : yr[tsw_pkg::COORD_W-1:0];
         b_job_in.x1 = b_job_in.x0;
         b_job_in.y1 = b_job_in.y0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         a_op_ff  <= in_op;
         a_idx_ff <= in_idx;
         a_val_ff <= in_val;
         a_sx_ff  <= a_sx_in;
         a_sy_ff  <= a_sy_in;
      end
      if (a_take) begin
         b_job_ff <= b_job_in;
      end
   end

   assign job_valid = b_valid_ff;
   assign job       = b_job_ff;

endmodule

@@ hdl/tsw_issue.sv @@
// Memory sequencer: one write, one nearest read or four bilinear reads per job.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

module tsw_issue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  tsw_pkg::job_type              job,
   input  logic [tsw_pkg::DIM_W-1:0]     width,
   input  logic                          credit_ok,
   output logic                          res_issue,
   output logic                          ram_we,
   output logic [tsw_pkg::ADDR_W-1:0]    ram_addr,
   output logic [tsw_pkg::PIXEL_W-1:0]   ram_wdata,
   output logic                          tag_valid,
   output tsw_pkg::tag_type              tag
);

   logic                          c_valid_ff, c_valid_in;
   tsw_pkg::job_type              c_job_ff;
   tsw_pkg::step_type             step_ff, step_in;
   logic                          tag_valid_ff;
   tsw_pkg::tag_type              tag_ff, tag_in;

   logic                          is_write, last_step, result_step, fire, c_done;
   logic [tsw_pkg::COORD_W-1:0]   xs, ys;
   logic [tsw_pkg::LIN_W-1:0]     lin;
   logic                          in_store, idx_ok;

   assign is_write    = (c_job_ff.op == tsw_pkg::OP_WRITE);
   assign last_step   = is_write || (c_job_ff.mode == tsw_pkg::MODE_NEAREST)
                        || (step_ff == tsw_pkg::STEP_X1Y1);
   assign result_step = !is_write && last_step;
   // only the read that completes a sample needs room downstream
   assign fire        = c_valid_ff && (!result_step || credit_ok);
   assign c_done      = fire && last_step;
   assign job_ready   = !c_valid_ff || c_done;
   assign c_valid_in  = (job_valid && job_ready) || (c_valid_ff && !c_done);

   always_comb begin
      unique case (step_ff)
         tsw_pkg::STEP_X0Y0: begin xs = c_job_ff.x0; ys = c_job_ff.y0; end
         tsw_pkg::STEP_X0Y1: begin xs = c_job_ff.x0; ys = c_job_ff.y1; end
         tsw_pkg::STEP_X1Y0: begin xs = c_job_ff.x1; ys = c_job_ff.y0; end
         tsw_pkg::STEP_X1Y1: begin xs = c_job_ff.x1; ys = c_job_ff.y1; end
      endcase
   end

   assign lin      = tsw_pkg::LIN_W'(xs) + tsw_pkg::LIN_W'(ys) * tsw_pkg::LIN_W'(width);
   assign in_store = (32'(lin) < tsw_pkg::PIXEL_DEPTH);
   assign idx_ok   = (32'(c_job_ff.idx) < tsw_pkg::PIXEL_DEPTH);

   assign ram_we    = fire && is_write && idx_ok;
   assign ram_addr  = is_write ? tsw_pkg::ADDR_W'(c_job_ff.idx) : tsw_pkg::ADDR_W'(lin);
   assign ram_wdata = c_job_ff.val;
   assign res_issue = fire && result_step;

   always_comb begin
      if (c_done) begin
         step_in = tsw_pkg::STEP_X0Y0;
      end else if (fire) begin
         step_in = tsw_pkg::step_type'(step_ff + 2'd1);
      end else begin
         step_in = step_ff;
      end
      tag_in.last = result_step;
      tag_in.mode = c_job_ff.mode;
      tag_in.zero = !in_store;
      tag_in.fx   = c_job_ff.fx;
      tag_in.fy   = c_job_ff.fy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         step_ff      <= tsw_pkg::STEP_X0Y0;
         tag_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         step_ff      <= step_in;
         tag_valid_ff <= fire && !is_write;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         c_job_ff <= job;
      end
      tag_ff <= tag_in;
   end

   assign tag_valid = tag_valid_ff;
   assign tag       = tag_ff;

endmodule

@@ hdl/tsw_filter.sv @@
// Texel filter: collects the read data, blends horizontally then vertically, rounds.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

module tsw_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tsw_pkg::PIXEL_W-1:0]   rd_data,
   input  logic                          tag_valid,
   input  tsw_pkg::tag_type              tag,
   output logic                          res_valid,
   output logic [tsw_pkg::PIXEL_W-1:0]   res_data
);

   localparam int HPROD_W = tsw_pkg::CHAN_W + tsw_pkg::WEIGHT_W;
   localparam int VPROD_W = tsw_pkg::ACC_W + 1;

   logic [tsw_pkg::PIXEL_W-1:0]   data_in;
   logic [tsw_pkg::PIXEL_W-1:0]   tex_ff [3];   // texels of the sample, oldest first

   logic                          p1_valid_ff;
   tsw_pkg::mode_type             p1_mode_ff;
   logic [tsw_pkg::PIXEL_W-1:0]   p1_texel_ff;
   logic [tsw_pkg::FRAC_W-1:0]    p1_fy_ff;
   logic [tsw_pkg::HBLEND_W-1:0]  p1_top_ff [tsw_pkg::NUM_CHAN];
   logic [tsw_pkg::HBLEND_W-1:0]  p1_bot_ff [tsw_pkg::NUM_CHAN];
   logic [tsw_pkg::HBLEND_W-1:0]  p1_top_in [tsw_pkg::NUM_CHAN];
   logic [tsw_pkg::HBLEND_W-1:0]  p1_bot_in [tsw_pkg::NUM_CHAN];

   logic                          p2_valid_ff;
   tsw_pkg::mode_type             p2_mode_ff;
   logic [tsw_pkg::PIXEL_W-1:0]   p2_texel_ff;
   logic [tsw_pkg::ACC_W-1:0]     p2_sum_ff [tsw_pkg::NUM_CHAN];
   logic [tsw_pkg::ACC_W-1:0]     p2_sum_in [tsw_pkg::NUM_CHAN];

   logic [tsw_pkg::PIXEL_W-1:0]   blended;
   logic                          p1_load;

   assign data_in = tag.zero ? '0 : rd_data;
   assign p1_load = tag_valid && tag.last;

   // horizontal blend: top row from texels 0 and 2, bottom row from 1 and 3
   always_comb begin
      logic [tsw_pkg::WEIGHT_W-1:0] wx0, wx1;
      wx0 = tsw_pkg::WEIGHT_ONE - tsw_pkg::WEIGHT_W'(tag.fx);
      wx1 = tsw_pkg::WEIGHT_W'(tag.fx);
      for (int ch = 0; ch < tsw_pkg::NUM_CHAN; ch++) begin
         p1_top_in[ch] = tsw_pkg::HBLEND_W'(
            HPROD_W'(tex_ff[0][ch*tsw_pkg::CHAN_W +: tsw_pkg::CHAN_W]) * HPROD_W'(wx0)
          + HPROD_W'(tex_ff[2][ch*tsw_pkg::CHAN_W +: tsw_pkg::CHAN_W]) * HPROD_W'(wx1));
         p1_bot_in[ch] = tsw_pkg::HBLEND_W'(
            HPROD_W'(tex_ff[1][ch*tsw_pkg::CHAN_W +: tsw_pkg::CHAN_W]) * HPROD_W'(wx0)
          + HPROD_W'(data_in[ch*tsw_pkg::CHAN_W +: tsw_pkg::CHAN_W]) * HPROD_W'(wx1));
      end
   end

   // vertical blend
   always_comb begin
      logic [tsw_pkg::WEIGHT_W-1:0] wy0, wy1;
      wy0 = tsw_pkg::WEIGHT_ONE - tsw_pkg::WEIGHT_W'(p1_fy_ff);
      wy1 = tsw_pkg::WEIGHT_W'(p1_fy_ff);
      for (int ch = 0; ch < tsw_pkg::NUM_CHAN; ch++) begin
         p2_sum_in[ch] = tsw_pkg::ACC_W'(
            VPROD_W'(p1_top_ff[ch]) * VPROD_W'(wy0)
          + VPROD_W'(p1_bot_ff[ch]) * VPROD_W'(wy1));
      end
   end

   // round to nearest and saturate
   always_comb begin
      logic [tsw_pkg::ACC_W:0]   rounded;
      logic [tsw_pkg::CHAN_W:0]  chan;
      blended = '0;
      for (int ch = 0; ch < tsw_pkg::NUM_CHAN; ch++) begin
         rounded = (tsw_pkg::ACC_W + 1)'(p2_sum_ff[ch]) + tsw_pkg::ROUND_HALF;
         chan    = rounded[tsw_pkg::ACC_W:2*tsw_pkg::FRAC_W];
         if (chan > tsw_pkg::CHAN_MAX) begin
            chan = tsw_pkg::CHAN_MAX;
         end
         blended[ch*tsw_pkg::CHAN_W +: tsw_pkg::CHAN_W] = chan[tsw_pkg::CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_load;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_valid && !tag.last) begin
         tex_ff[0] <= tex_ff[1];
         tex_ff[1] <= tex_ff[2];
         tex_ff[2] <= data_in;
      end
      p1_mode_ff  <= tag.mode;
      p1_texel_ff <= data_in;
      p1_fy_ff    <= tag.fy;
      p1_top_ff   <= p1_top_in;
      p1_bot_ff   <= p1_bot_in;
      p2_mode_ff  <= p1_mode_ff;
      p2_texel_ff <= p1_texel_ff;
      p2_sum_ff   <= p2_sum_in;
   end

   assign res_valid = p2_valid_ff;
   assign res_data  = (p2_mode_ff == tsw_pkg::MODE_BILINEAR) ? blended : p2_texel_ff;

endmodule

@@ hdl/texture_sampler_wrap_unit.sv @@
// Texture sampler with repeat wrap: top level, register port and result buffer.
// Depends on tsw_pkg, tsw_ram, tsw_coord, tsw_issue and tsw_filter.
`timescale 1ns / 1ps

// The block keeps an RGBA8 image in a single-port 65536 x 32 pixel RAM and
// serves colour samples from it. A request word with tuser low writes one
// pixel at pixel_index (x + y * width) and produces no response; a word with
// tuser high samples at u, v (unsigned 0.16 fractions of width and height) and
// produces exactly one response word, in request order. Nearest mode takes the
// texel at the rounded scaled coordinate, wrapped to the image; bilinear mode
// blends the floor texel with its right, lower and lower-right neighbours,
// wrapping at the right and bottom edges, with 16-bit weights, each channel
// rounded to nearest. Throughput is set by the RAM port, one access a cycle
// unless result credit is used up: a write or a nearest sample is one access,
// a bilinear sample four (its texel reads). Back-to-back requests are taken
// while earlier ones are in flight. A sample passes front stages A and B, the
// sequencer, the RAM read register and filter stages p1 and p2 to an 8-word
// result buffer, which absorbs output stalls before the input backs up.
// Size registers take 0 as 1 and anything above 256 as 256. The RAM is not
// cleared at reset: sampling a pixel that was never written returns an
// undefined colour. Write the registers only while the block is idle.

module texture_sampler_wrap_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] pixel_index, [47:16] pixel_value, [63:48] u_coord, [79:64] v_coord
   input  logic [tsw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic                              req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] colour
   output logic [tsw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register port
   input  logic                              csr_we,
   input  logic [tsw_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tsw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration, held already clamped to 1..MAX_DIM
   logic [tsw_pkg::DIM_W-1:0]     width_ff, height_ff, size_in;
   tsw_pkg::mode_type             mode_ff;

   // front end to sequencer
   logic                          job_valid, job_ready;
   tsw_pkg::job_type              job;

   // sequencer to RAM and filter
   logic                          ram_we;
   logic [tsw_pkg::ADDR_W-1:0]    ram_addr;
   logic [tsw_pkg::PIXEL_W-1:0]   ram_wdata, ram_rdata;
   logic                          tag_valid;
   tsw_pkg::tag_type              tag;
   logic                          res_issue;

   // filter to result buffer
   logic                          res_valid;
   logic [tsw_pkg::PIXEL_W-1:0]   res_data;

   // result buffer; credit counts samples past the RAM plus words buffered
   logic [tsw_pkg::PIXEL_W-1:0]   buf_ff [tsw_pkg::OUT_DEPTH];
   logic [tsw_pkg::OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tsw_pkg::OUT_CNT_W-1:0] fill_ff, fill_in, credit_ff, credit_in;
   logic                          pop, credit_ok;

   always_comb begin
      if (csr_wdata == '0) begin
         size_in = tsw_pkg::DIM_W'(1);
      end else if (csr_wdata > tsw_pkg::DIM_W'(tsw_pkg::MAX_DIM)) begin
         size_in = tsw_pkg::DIM_W'(tsw_pkg::MAX_DIM);
      end else begin
         size_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tsw_pkg::DIM_W'(1);
         height_ff <= tsw_pkg::DIM_W'(1);
         mode_ff   <= tsw_pkg::MODE_NEAREST;
      end else if (csr_we) begin
         unique case (csr_addr)
            tsw_pkg::CSR_WIDTH:  width_ff  <= size_in;
            tsw_pkg::CSR_HEIGHT: height_ff <= size_in;
            tsw_pkg::CSR_MODE:   mode_ff   <= tsw_pkg::mode_type'(csr_wdata[0]);
            default: ;   // unused index
         endcase
      end
   end

   tsw_coord u_coord (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (tsw_pkg::op_type'(req_tuser)),
      .in_idx    (req_tdata[tsw_pkg::REQ_IDX_LSB +: tsw_pkg::INDEX_W]),
      .in_val    (req_tdata[tsw_pkg::REQ_VAL_LSB +: tsw_pkg::PIXEL_W]),
      .in_u      (req_tdata[tsw_pkg::REQ_U_LSB +: tsw_pkg::FRAC_W]),
      .in_v      (req_tdata[tsw_pkg::REQ_V_LSB +: tsw_pkg::FRAC_W]),
      .width     (width_ff),
      .height    (height_ff),
      .mode      (mode_ff),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   tsw_issue u_issue (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .width     (width_ff),
      .credit_ok (credit_ok),
      .res_issue (res_issue),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .tag_valid (tag_valid),
      .tag       (tag)
   );

   tsw_ram #(
      .WIDTH (tsw_pkg::PIXEL_W),
      .DEPTH (tsw_pkg::PIXEL_DEPTH)
   ) u_pixel_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   tsw_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .rd_data   (ram_rdata),
      .tag_valid (tag_valid),
      .tag       (tag),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // credit guarantees the buffer has room when a filtered word arrives
   assign pop       = rsp_tvalid && rsp_tready;
   assign credit_ok = (credit_ff < tsw_pkg::OUT_CNT_W'(tsw_pkg::OUT_DEPTH));
   assign credit_in = credit_ff + tsw_pkg::OUT_CNT_W'(res_issue) - tsw_pkg::OUT_CNT_W'(pop);
   assign fill_in   = fill_ff + tsw_pkg::OUT_CNT_W'(res_valid) - tsw_pkg::OUT_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         if (res_valid) begin
            wr_ptr_ff <= wr_ptr_ff + tsw_pkg::OUT_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + tsw_pkg::OUT_PTR_W'(1);
         end
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         buf_ff[wr_ptr_ff] <= res_data;
      end
   end

   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = buf_ff[rd_ptr_ff];

endmodule

@@ hdl/tsw_checker.sv @@
// Port-level checks for the texture sampler, bound to the top level.
// Depends on tsw_pkg and texture_sampler_wrap_unit.
`timescale 1ns / 1ps

module tsw_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [tsw_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // reset empties the result buffer
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response word valid right after reset");

   // reset empties the front stage, so a request can be taken at once
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request side not ready right after reset");

   // a buffered response word is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response word dropped or changed");

endmodule

bind texture_sampler_wrap_unit tsw_checker u_tsw_checker (.*);
